/* design/nfc_frame_uid_parser_assert.svh */
// ----------------------------------------------------------------------------
// nfc_frame_uid_parser assertion macros
// Shorthand for clocked implication checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef NFC_FRAME_UID_PARSER_ASSERT_SVH
`define NFC_FRAME_UID_PARSER_ASSERT_SVH

// same-cycle implication
`define NFP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfp check failed: same-cycle rule");

// next-cycle implication
`define NFP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfp check failed: next-cycle rule");

`endif

/* design/nfp_pkg.sv */
// ----------------------------------------------------------------------------
// nfp_pkg
// Types and constants shared by the NFC frame UID parser modules.
// ----------------------------------------------------------------------------
package nfp_pkg;

   localparam int MAX_FRAME  = 128;
   localparam int MAX_UID    = 10;
   localparam int MIN_LEN    = 8;
   localparam int UID_OFFSET = 8;
   localparam int POS_W      = 9;

   localparam logic [7:0] PREAMBLE  = 8'h00;
   localparam logic [7:0] SOF_CODE  = 8'hFF;
   localparam logic [7:0] TFI_CODE  = 8'hD5;
   localparam logic [7:0] CMD_CODE  = 8'h4B;

   // header byte positions
   localparam logic [POS_W-1:0] HDR_POS_SOF0 = POS_W'(0);
   localparam logic [POS_W-1:0] HDR_POS_SOF1 = POS_W'(1);
   localparam logic [POS_W-1:0] HDR_POS_SOF2 = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_POS_LEN  = POS_W'(3);

   // body byte positions
   localparam logic [POS_W-1:0] BODY_POS_TFI    = POS_W'(0);
   localparam logic [POS_W-1:0] BODY_POS_CMD    = POS_W'(1);
   localparam logic [POS_W-1:0] BODY_POS_NTG    = POS_W'(2);
   localparam logic [POS_W-1:0] BODY_POS_UIDLEN = POS_W'(7);

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_BAD_START  = 3'd1;
   localparam logic [2:0] STAT_LEN_CSUM   = 3'd2;
   localparam logic [2:0] STAT_TOO_LONG   = 3'd3;
   localparam logic [2:0] STAT_WRONG_CODE = 3'd4;
   localparam logic [2:0] STAT_SHORT      = 3'd5;
   localparam logic [2:0] STAT_NO_TARGET  = 3'd6;
   localparam logic [2:0] STAT_BAD_UIDLEN = 3'd7;

   localparam logic KIND_UID    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic       start_req;
      logic [7:0] rx_byte;
   } nfp_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] uid_byte;
      logic [3:0] uid_index;
      logic [3:0] uid_length;
      logic [2:0] status;
      logic       done_res;
   } nfp_result_type;

   typedef struct packed {
      logic           valid;
      nfp_result_type data;
   } nfp_result_bus_type;

endpackage

/* design/nfp_in_stage.sv */
// ----------------------------------------------------------------------------
// nfp_in_stage
// Input register: holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module nfp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  nfp_pkg::nfp_item_type in_item,
   output logic                  item_valid,
   output nfp_pkg::nfp_item_type item,
   input  logic                  item_take
);
   import nfp_pkg::*;

   logic         valid_ff, valid_in;
   nfp_item_type item_ff, item_in;

   assign in_ready   = !valid_ff || item_take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

/* design/nfp_parse_core.sv */
// ----------------------------------------------------------------------------
// nfp_parse_core
// Frame state and per-word header/body checks; yields at most one result.
// ----------------------------------------------------------------------------
module nfp_parse_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  nfp_pkg::nfp_item_type       item,
   input  logic                        out_free,
   output logic                        item_take,
   output nfp_pkg::nfp_result_bus_type result
);
   import nfp_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic             body_ff, body_in, body_eff;
   logic             idle_ff, idle_in, idle_eff;
   logic             sof_ok_ff, sof_ok_in;
   logic [7:0]       len_ff, len_in;
   logic [3:0]       found_ff, found_in;
   logic [2:0]       pend_ff, pend_in;

   logic             fin, emit;
   logic [2:0]       fin_st;
   logic [7:0]       b;
   logic [7:0]       lcs_sum;
   logic [POS_W-1:0] len_ext;

   assign b       = item.rx_byte;
   assign lcs_sum = len_ff + b;
   assign len_ext = {1'b0, len_ff};

   always_comb begin
      idle_eff = idle_ff;
      body_eff = body_ff;
      pos_eff  = pos_ff;
      if (item.start_req) begin
         idle_eff = 1'b0;
         body_eff = 1'b0;
         pos_eff  = '0;
      end
      idle_in   = idle_eff;
      body_in   = body_eff;
      pos_in    = pos_eff;
      sof_ok_in = sof_ok_ff;
      len_in    = len_ff;
      found_in  = found_ff;
      pend_in   = pend_ff;
      fin       = 1'b0;
      fin_st    = STAT_OK;
      emit      = 1'b0;

      if (!idle_eff) begin
         if (!body_eff) begin
            pos_in = pos_eff + POS_W'(1);
            case (pos_eff)
               HDR_POS_SOF0: sof_ok_in = (b == PREAMBLE);
               HDR_POS_SOF1: sof_ok_in = sof_ok_ff && (b == PREAMBLE);
               HDR_POS_SOF2: begin
                  if (!(sof_ok_ff && (b == SOF_CODE))) begin
                     fin    = 1'b1;
                     fin_st = STAT_BAD_START;
                  end
               end
               HDR_POS_LEN: len_in = b;
               default: begin
                  if (lcs_sum != 8'h00) begin
                     fin    = 1'b1;
                     fin_st = STAT_LEN_CSUM;
                  end else if ((len_ext + POS_W'(2)) > POS_W'(MAX_FRAME)) begin
                     fin    = 1'b1;
                     fin_st = STAT_TOO_LONG;
                  end else begin
                     body_in  = 1'b1;
                     pos_in   = '0;
                     pend_in  = STAT_OK;
                     found_in = '0;
                  end
               end
            endcase
         end else begin
            case (pos_eff)
               BODY_POS_TFI: begin
                  if (b != TFI_CODE) begin
                     pend_in = STAT_WRONG_CODE;
                  end
               end
               BODY_POS_CMD: begin
                  if (pend_in == STAT_OK && b != CMD_CODE) begin
                     pend_in = STAT_WRONG_CODE;
                  end
                  if (pend_in == STAT_OK && len_ff < 8'(MIN_LEN)) begin
                     pend_in = STAT_SHORT;
                  end
               end
               BODY_POS_NTG: begin
                  if (pend_in == STAT_OK && b == 8'h00) begin
                     pend_in = STAT_NO_TARGET;
                  end
               end
               BODY_POS_UIDLEN: begin
                  if (pend_in == STAT_OK) begin
                     if (b == 8'h00 || b > 8'(MAX_UID) ||
                         ({1'b0, b} + POS_W'(UID_OFFSET)) > len_ext) begin
                        pend_in = STAT_BAD_UIDLEN;
                     end else begin
                        found_in = b[3:0];
                     end
                  end
               end
               default: ;
            endcase
            if (pos_eff == len_ext + POS_W'(1)) begin
               fin    = 1'b1;
               fin_st = pend_in;
            end else begin
               pos_in = pos_eff + POS_W'(1);
               emit   = (pend_in == STAT_OK) && (found_in != '0) &&
                        (pos_eff >= POS_W'(UID_OFFSET)) &&
                        (pos_eff < POS_W'(UID_OFFSET) + POS_W'(found_in));
            end
         end
      end

      if (fin) begin
         body_in = 1'b0;
         idle_in = 1'b1;
         pos_in  = '0;
      end
   end

   assign item_take = item_valid && (!(fin || emit) || out_free);

   always_comb begin
      result.valid = item_valid && (fin || emit);
      if (fin) begin
         result.data.kind       = KIND_STATUS;
         result.data.uid_byte   = '0;
         result.data.uid_index  = '0;
         result.data.uid_length = (fin_st == STAT_OK) ? found_in : 4'd0;
         result.data.status     = fin_st;
         result.data.done_res   = 1'b1;
      end else begin
         result.data.kind       = KIND_UID;
         result.data.uid_byte   = b;
         result.data.uid_index  = 4'(pos_eff - POS_W'(UID_OFFSET));
         result.data.uid_length = found_in;
         result.data.status     = STAT_OK;
         result.data.done_res   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         body_ff   <= 1'b0;
         idle_ff   <= 1'b1;
         sof_ok_ff <= 1'b0;
         len_ff    <= '0;
         found_ff  <= '0;
         pend_ff   <= STAT_OK;
      end else if (item_take) begin
         pos_ff    <= pos_in;
         body_ff   <= body_in;
         idle_ff   <= idle_in;
         sof_ok_ff <= sof_ok_in;
         len_ff    <= len_in;
         found_ff  <= found_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

/* design/nfp_out_stage.sv */
// ----------------------------------------------------------------------------
// nfp_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module nfp_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  nfp_pkg::nfp_result_bus_type result,
   input  logic                        item_take,
   output logic                        out_free,
   output logic                        out_valid,
   input  logic                        out_ready,
   output nfp_pkg::nfp_result_type     out_data
);
   import nfp_pkg::*;

   logic           valid_ff, valid_in;
   nfp_result_type data_ff, data_in;

   assign out_free  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (result.valid && item_take) begin
         valid_in = 1'b1;
         data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* design/nfc_frame_uid_parser.sv */
// ----------------------------------------------------------------------------
// nfc_frame_uid_parser
// Parses NFC controller information frames byte by byte and emits the UID.
// ----------------------------------------------------------------------------
// Takes one received byte per word (req_tuser set on the first byte of a
// read), checks the 00 00 FF start code, LEN/LCS and frame size, then checks
// the passive-target list response body. Each UID byte goes out as a UID word
// as it arrives; one status word (rsp_tlast set) ends each frame that runs to
// its end, at the failing header byte or on the last body byte. A new start
// mid-frame drops the old frame without a word, and bytes outside a frame are
// ignored. A byte is accepted every cycle while results drain; its result
// word passes through the input register and then the result register
// around the parse logic.
module nfc_frame_uid_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] uid_byte, [11:8] uid_index,
                                    // [15:12] uid_length, [18:16] status
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // done_res
);
   import nfp_pkg::*;

   nfp_item_type       req_item, item;
   logic               item_valid, item_take, out_free;
   nfp_result_bus_type result;
   nfp_result_type     out_data;

   assign req_item.rx_byte   = req_tdata;
   assign req_item.start_req = req_tuser;

   nfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   nfp_parse_core u_parse_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .item_take  (item_take),
      .result     (result)
   );

   nfp_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .item_take (item_take),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {5'd0, out_data.status, out_data.uid_length,
                       out_data.uid_index, out_data.uid_byte};
   assign rsp_tuser = out_data.kind;
   assign rsp_tlast = out_data.done_res;

endmodule

/* design/nfp_checker.sv */
// ----------------------------------------------------------------------------
// nfp_checker
// Port-level checks on the result stream of the NFC frame UID parser.
// ----------------------------------------------------------------------------
`include "nfc_frame_uid_parser_assert.svh"

module nfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   `NFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `NFP_ASSERT_NOW(a_uid_word_fields, clock, reset, rsp_tvalid && !rsp_tuser, (rsp_tdata[18:16] == 3'd0) && !rsp_tlast)
   `NFP_ASSERT_NOW(a_status_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && (rsp_tdata[11:0] == 12'd0))
   `NFP_ASSERT_NOW(a_error_no_uid, clock, reset, rsp_tvalid && (rsp_tdata[18:16] != 3'd0), rsp_tdata[15:12] == 4'd0)
   `NFP_ASSERT_NOW(a_uid_index_range, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[11:8] < rsp_tdata[15:12])

endmodule

bind nfc_frame_uid_parser nfp_checker u_nfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
